>>> design/lbm_d2q9_bgk_collision_defines.svh
// Assertion macros shared by the D2Q9 collision design.
`ifndef LBM_D2Q9_BGK_COLLISION_DEFINES_SVH
`define LBM_D2Q9_BGK_COLLISION_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LBM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked during reset too.
`define LBM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/lbm_pkg.sv
// Package with the types, constants and helpers of the D2Q9 collision design.
package lbm_pkg;

  localparam int DATA_W        = 24;
  localparam int FRAC_BITS_DEF = 20;
  localparam int RELAX_W       = 22;
  localparam int RELAX_FRAC    = 20;
  localparam int NDIR          = 9;
  localparam int RHO_W         = 28;
  localparam int USQ_W         = 49;
  localparam int QUOT_BITS     = 23;
  localparam int DIV_LAT       = QUOT_BITS + 2;
  localparam int LANE_LAT      = 12;
  localparam int SAT_W         = 96;

  localparam logic [RELAX_W-1:0] INV_RELAX_RESET = 22'd953251;

  localparam int EX_TAB [NDIR] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
  localparam int EY_TAB [NDIR] = '{0, 0, -1, 0, 1, -1, -1, 1, 1};
  localparam int WCLS_TAB [NDIR] = '{0, 1, 1, 1, 1, 2, 2, 2, 2};

  localparam logic signed [SAT_W-1:0] SAT_MAX = 96'sd8388607;
  localparam logic signed [SAT_W-1:0] SAT_MIN = -96'sd8388608;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef struct packed {
    data_t                   ux;
    data_t                   uy;
    logic signed [USQ_W-1:0] usq;
    logic signed [RHO_W-1:0] rho;
  } lane_in_t;

  function automatic longint weight(input int cls, input int frac);
    longint one;
    one = 64'sd1 <<< frac;
    if (cls == 0) begin
      return (8 * one + 9) / 18;
    end else if (cls == 1) begin
      return (2 * one + 9) / 18;
    end
    return (2 * one + 36) / 72;
  endfunction

  function automatic data_t sat24(input logic signed [SAT_W-1:0] v);
    if (v > SAT_MAX) begin
      return data_t'(SAT_MAX);
    end else if (v < SAT_MIN) begin
      return data_t'(SAT_MIN);
    end
    return data_t'(v);
  endfunction

endpackage

>>> design/lbm_div.sv
// Pipelined restoring divider giving the saturated velocity from momentum and density.
module lbm_div #(
  parameter int FRAC_BITS = lbm_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic signed [lbm_pkg::RHO_W-1:0]    num,
  input  logic signed [lbm_pkg::RHO_W-1:0]    den,
  output lbm_pkg::data_t                      quot
);

  localparam int QB  = lbm_pkg::QUOT_BITS;
  localparam int DW  = lbm_pkg::RHO_W - 1;
  localparam int NW  = lbm_pkg::RHO_W + FRAC_BITS;
  localparam int RW  = ((NW > DW + QB) ? NW : DW + QB) + 1;

  logic [RW-1:0] rem_r  [QB+1];
  logic [DW-1:0] den_r  [QB+1];
  logic [QB-1:0] q_r    [QB+1];
  logic          neg_r  [QB+1];
  logic          ovf_r  [QB+1];
  logic          zero_r [QB+1];
  lbm_pkg::data_t quot_r;

  logic [RW-1:0] nmag_nxt;
  logic [DW-1:0] dmag_nxt;

  always_comb begin
    logic [lbm_pkg::RHO_W-1:0] mag;
    mag = num[lbm_pkg::RHO_W-1] ? lbm_pkg::RHO_W'(-num) : lbm_pkg::RHO_W'(num);
    nmag_nxt = RW'(mag) << FRAC_BITS;
    dmag_nxt = den[DW-1:0];
  end

  always_ff @(posedge clk) begin
    rem_r[0]  <= nmag_nxt;
    den_r[0]  <= dmag_nxt;
    q_r[0]    <= '0;
    neg_r[0]  <= num[lbm_pkg::RHO_W-1];
    zero_r[0] <= (den <= 0);
    ovf_r[0]  <= (nmag_nxt >= (RW'(dmag_nxt) << QB));
  end

  for (genvar s = 1; s <= QB; s++) begin : g_stage
    logic [RW-1:0] trial;
    logic          take;
    assign trial = RW'(den_r[s-1]) << (QB - s);
    assign take  = (rem_r[s-1] >= trial);

    always_ff @(posedge clk) begin
      rem_r[s]  <= take ? (rem_r[s-1] - trial) : rem_r[s-1];
      q_r[s]    <= q_r[s-1] | (take ? (QB'(1) << (QB - s)) : '0);
      den_r[s]  <= den_r[s-1];
      neg_r[s]  <= neg_r[s-1];
      ovf_r[s]  <= ovf_r[s-1];
      zero_r[s] <= zero_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (zero_r[QB]) begin
      quot_r <= '0;
    end else if (ovf_r[QB]) begin
      quot_r <= neg_r[QB] ? lbm_pkg::data_t'(lbm_pkg::SAT_MIN)
                          : lbm_pkg::data_t'(lbm_pkg::SAT_MAX);
    end else if (neg_r[QB]) begin
      quot_r <= -lbm_pkg::data_t'({1'b0, q_r[QB]});
    end else begin
      quot_r <= lbm_pkg::data_t'({1'b0, q_r[QB]});
    end
  end

  assign quot = quot_r;

endmodule

>>> design/lbm_lane.sv
// One direction lane: equilibrium value and relaxation of one distribution.
module lbm_lane #(
  parameter int FRAC_BITS = lbm_pkg::FRAC_BITS_DEF,
  parameter int EX        = 0,
  parameter int EY        = 0,
  parameter int WCLS      = 0
) (
  input  logic                          clk,
  input  lbm_pkg::lane_in_t             lin,
  input  lbm_pkg::data_t                f_in,
  input  logic [lbm_pkg::RELAX_W-1:0]   irt,
  output lbm_pkg::data_t                f_out
);

  localparam int P_W   = 26;
  localparam int PSQ_W = 52;
  localparam int TW    = 2 * FRAC_BITS + 32;
  localparam int WW    = FRAC_BITS + 1;
  localparam int M1W   = lbm_pkg::DATA_W + WW;
  localparam int FW_W  = 25;
  localparam int M2W   = FW_W + lbm_pkg::RHO_W;
  localparam int FQW   = 51 - FRAC_BITS;
  localparam int DFW   = FQW + 1;
  localparam int M3W   = DFW + lbm_pkg::RELAX_W + 1;
  localparam int RF    = lbm_pkg::RELAX_FRAC;

  localparam logic signed [WW-1:0] WGT   = WW'(lbm_pkg::weight(WCLS, FRAC_BITS));
  localparam logic signed [TW-1:0] TWO_T = TW'(2) <<< (2 * FRAC_BITS);

  logic signed [P_W-1:0]           p_r, p2_r;
  logic signed [PSQ_W-1:0]         psq_r;
  logic signed [TW-1:0]            t_r;
  lbm_pkg::data_t                  fac_r;
  logic signed [M1W-1:0]           m1_r;
  logic signed [FW_W-1:0]          fw_r;
  logic signed [M2W-1:0]           m2_r;
  logic signed [FQW-1:0]           feq_r;
  logic signed [DFW-1:0]           diff_r;
  logic signed [M3W-1:0]           m3_r, dl_r;
  lbm_pkg::data_t                  out_r;
  logic signed [lbm_pkg::USQ_W-1:0] usq_d [1:2];
  logic signed [lbm_pkg::RHO_W-1:0] rho_d [1:6];
  lbm_pkg::data_t                  f_d   [1:11];

  logic signed [lbm_pkg::DATA_W-1:0] fac_nxt;
  logic signed [FW_W-1:0]            fw_nxt;
  logic signed [FQW-1:0]             feq_nxt;
  logic signed [M3W-1:0]             dl_nxt;

  always_comb begin
    logic signed [TW:0]  xt;
    logic signed [M1W:0] x1;
    logic signed [M2W:0] x2;
    logic signed [M3W:0] x3;
    xt = (TW+1)'(t_r) + ((TW+1)'(1) <<< FRAC_BITS);
    if (t_r[TW-1]) begin
      xt = xt - (TW+1)'(1);
    end
    fac_nxt = lbm_pkg::sat24(lbm_pkg::SAT_W'(xt >>> (FRAC_BITS + 1)));
    x1 = (M1W+1)'(m1_r) + ((M1W+1)'(1) <<< (FRAC_BITS - 1));
    if (m1_r[M1W-1]) begin
      x1 = x1 - (M1W+1)'(1);
    end
    fw_nxt = FW_W'(x1 >>> FRAC_BITS);
    x2 = (M2W+1)'(m2_r) + ((M2W+1)'(1) <<< (FRAC_BITS - 1));
    if (m2_r[M2W-1]) begin
      x2 = x2 - (M2W+1)'(1);
    end
    feq_nxt = FQW'(x2 >>> FRAC_BITS);
    x3 = (M3W+1)'(m3_r) + ((M3W+1)'(1) <<< (RF - 1));
    if (m3_r[M3W-1]) begin
      x3 = x3 - (M3W+1)'(1);
    end
    dl_nxt = M3W'(x3 >>> RF);
  end

  always_ff @(posedge clk) begin
    p_r    <= P_W'(EX) * P_W'(lin.ux) + P_W'(EY) * P_W'(lin.uy);
    p2_r   <= p_r;
    psq_r  <= PSQ_W'(p_r) * PSQ_W'(p_r);
    t_r    <= TWO_T + ((TW'(p2_r) * 6) <<< FRAC_BITS) + TW'(psq_r) * 9
              - TW'(usq_d[2]) * 3;
    fac_r  <= fac_nxt;
    m1_r   <= M1W'(fac_r) * M1W'(WGT);
    fw_r   <= fw_nxt;
    m2_r   <= M2W'(fw_r) * M2W'(rho_d[6]);
    feq_r  <= feq_nxt;
    diff_r <= DFW'(feq_r) - DFW'(f_d[8]);
    m3_r   <= M3W'(diff_r) * M3W'($signed({1'b0, irt}));
    dl_r   <= dl_nxt;
    out_r  <= lbm_pkg::sat24(lbm_pkg::SAT_W'(f_d[11]) + lbm_pkg::SAT_W'(dl_r));
    usq_d[1] <= lin.usq;
    usq_d[2] <= usq_d[1];
    rho_d[1] <= lin.rho;
    f_d[1]   <= f_in;
    for (int i = 2; i <= 6; i++) begin
      rho_d[i] <= rho_d[i-1];
    end
    for (int i = 2; i <= 11; i++) begin
      f_d[i] <= f_d[i-1];
    end
  end

  assign f_out = out_r;

endmodule

>>> design/lbm_d2q9_bgk_collision.sv
// Top level of the D2Q9 BGK collision pipeline for one lattice cell per beat.
//
// The block takes one cell every clock cycle and returns its result after
// the input register and moment sums, a divider pipeline with one quotient
// bit per stage for each velocity component, the squared speed, the nine
// direction lanes and one output register. busy stays low, so a new cell
// may be started in every cycle. The receiver cannot stall: each result is
// present for exactly one cycle while out_valid is high. inv_relax_time must
// only be written while no cell is in flight.
module lbm_d2q9_bgk_collision #(
  parameter int FRAC_BITS = lbm_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [23:0]           in_d0,
  input  logic signed [23:0]           in_d1,
  input  logic signed [23:0]           in_d2,
  input  logic signed [23:0]           in_d3,
  input  logic signed [23:0]           in_d4,
  input  logic signed [23:0]           in_d5,
  input  logic signed [23:0]           in_d6,
  input  logic signed [23:0]           in_d7,
  input  logic signed [23:0]           in_d8,
  input  logic                         cfg_we,
  input  logic [lbm_pkg::RELAX_W-1:0]  cfg_wdata,
  output logic                         out_valid,
  output logic signed [23:0]           out_d0,
  output logic signed [23:0]           out_d1,
  output logic signed [23:0]           out_d2,
  output logic signed [23:0]           out_d3,
  output logic signed [23:0]           out_d4,
  output logic signed [23:0]           out_d5,
  output logic signed [23:0]           out_d6,
  output logic signed [23:0]           out_d7,
  output logic signed [23:0]           out_d8,
  output logic signed [23:0]           density,
  output logic signed [23:0]           vel_x,
  output logic signed [23:0]           vel_y
);

`include "lbm_d2q9_bgk_collision_defines.svh"

  localparam int ND      = lbm_pkg::NDIR;
  localparam int RW      = lbm_pkg::RHO_W;
  localparam int FL      = lbm_pkg::DIV_LAT + 1;
  localparam int LL      = lbm_pkg::LANE_LAT;
  localparam int TOT_LAT = 2 + lbm_pkg::DIV_LAT + 2 + LL + 1;
  localparam int UP_W    = $clog2(TOT_LAT + 1);

  logic                        acc;
  logic [TOT_LAT-1:0]          vld_r;
  logic [UP_W-1:0]             up_r;
  logic [lbm_pkg::RELAX_W-1:0] irt_r;

  lbm_pkg::data_t              fin_r [ND];
  lbm_pkg::data_t              fs1_r [ND];
  lbm_pkg::data_t              fdl_r [FL][ND];
  logic signed [RW-1:0]        rho_r, mx_r, my_r;
  logic signed [RW-1:0]        rdl_r [FL];
  lbm_pkg::data_t              ux, uy;
  lbm_pkg::data_t              ux1_r, uy1_r;
  logic signed [47:0]          sqx_r, sqy_r;
  lbm_pkg::lane_in_t           lin_r;
  lbm_pkg::data_t              lf_r  [ND];
  lbm_pkg::data_t              lane_out [ND];
  lbm_pkg::data_t              dden_r [LL];
  lbm_pkg::data_t              dux_r  [LL];
  lbm_pkg::data_t              duy_r  [LL];
  lbm_pkg::data_t              oute_r [ND];
  lbm_pkg::data_t              oden_r, oux_r, ouy_r;

  lbm_pkg::data_t              fin_nxt [ND];
  logic signed [RW-1:0]        rho_nxt, mx_nxt, my_nxt;

  assign busy = 1'b0;
  assign acc  = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      up_r  <= '0;
      irt_r <= lbm_pkg::INV_RELAX_RESET;
    end else begin
      vld_r <= {vld_r[TOT_LAT-2:0], acc};
      if (up_r != UP_W'(TOT_LAT)) begin
        up_r <= up_r + UP_W'(1);
      end
      if (cfg_we) begin
        irt_r <= cfg_wdata;
      end
    end
  end

  always_comb begin
    fin_nxt[0] = in_d0;
    fin_nxt[1] = in_d1;
    fin_nxt[2] = in_d2;
    fin_nxt[3] = in_d3;
    fin_nxt[4] = in_d4;
    fin_nxt[5] = in_d5;
    fin_nxt[6] = in_d6;
    fin_nxt[7] = in_d7;
    fin_nxt[8] = in_d8;
  end

  always_comb begin
    rho_nxt = '0;
    mx_nxt  = '0;
    my_nxt  = '0;
    for (int k = 0; k < ND; k++) begin
      rho_nxt = rho_nxt + RW'(fin_r[k]);
      if (lbm_pkg::EX_TAB[k] > 0) begin
        mx_nxt = mx_nxt + RW'(fin_r[k]);
      end else if (lbm_pkg::EX_TAB[k] < 0) begin
        mx_nxt = mx_nxt - RW'(fin_r[k]);
      end
      if (lbm_pkg::EY_TAB[k] > 0) begin
        my_nxt = my_nxt + RW'(fin_r[k]);
      end else if (lbm_pkg::EY_TAB[k] < 0) begin
        my_nxt = my_nxt - RW'(fin_r[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      fin_r <= fin_nxt;
    end
    fs1_r <= fin_r;
    rho_r <= rho_nxt;
    mx_r  <= mx_nxt;
    my_r  <= my_nxt;
    fdl_r[0] <= fs1_r;
    rdl_r[0] <= rho_r;
    for (int i = 1; i < FL; i++) begin
      fdl_r[i] <= fdl_r[i-1];
      rdl_r[i] <= rdl_r[i-1];
    end
  end

  lbm_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk  (clk),
    .num  (mx_r),
    .den  (rho_r),
    .quot (ux)
  );

  lbm_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk  (clk),
    .num  (my_r),
    .den  (rho_r),
    .quot (uy)
  );

  always_ff @(posedge clk) begin
    ux1_r     <= ux;
    uy1_r     <= uy;
    sqx_r     <= 48'(ux) * 48'(ux);
    sqy_r     <= 48'(uy) * 48'(uy);
    lin_r.ux  <= ux1_r;
    lin_r.uy  <= uy1_r;
    lin_r.usq <= lbm_pkg::USQ_W'(sqx_r) + lbm_pkg::USQ_W'(sqy_r);
    lin_r.rho <= rdl_r[FL-1];
    lf_r      <= fdl_r[FL-1];
  end

  for (genvar k = 0; k < ND; k++) begin : g_lane
    lbm_lane #(
      .FRAC_BITS (FRAC_BITS),
      .EX        (lbm_pkg::EX_TAB[k]),
      .EY        (lbm_pkg::EY_TAB[k]),
      .WCLS      (lbm_pkg::WCLS_TAB[k])
    ) u_lane (
      .clk   (clk),
      .lin   (lin_r),
      .f_in  (lf_r[k]),
      .irt   (irt_r),
      .f_out (lane_out[k])
    );
  end

  always_ff @(posedge clk) begin
    dden_r[0] <= lbm_pkg::sat24(lbm_pkg::SAT_W'(lin_r.rho));
    dux_r[0]  <= lin_r.ux;
    duy_r[0]  <= lin_r.uy;
    for (int i = 1; i < LL; i++) begin
      dden_r[i] <= dden_r[i-1];
      dux_r[i]  <= dux_r[i-1];
      duy_r[i]  <= duy_r[i-1];
    end
    oute_r <= lane_out;
    oden_r <= dden_r[LL-1];
    oux_r  <= dux_r[LL-1];
    ouy_r  <= duy_r[LL-1];
  end

  assign out_valid = vld_r[TOT_LAT-1];
  assign out_d0    = oute_r[0];
  assign out_d1    = oute_r[1];
  assign out_d2    = oute_r[2];
  assign out_d3    = oute_r[3];
  assign out_d4    = oute_r[4];
  assign out_d5    = oute_r[5];
  assign out_d6    = oute_r[6];
  assign out_d7    = oute_r[7];
  assign out_d8    = oute_r[8];
  assign density   = oden_r;
  assign vel_x     = oux_r;
  assign vel_y     = ouy_r;

  `LBM_ASSERT_IMP(a_vel_zero, out_valid && (density <= 0), (vel_x == 0) && (vel_y == 0), "Nonzero velocity for a cell without positive density.")
  `LBM_ASSERT_NXT(a_rst_quiet, !rst_n, !out_valid, "Result strobe right after reset.")
  `LBM_ASSERT_IMP(a_latency, up_r == UP_W'(TOT_LAT), out_valid == $past(acc, TOT_LAT), "Result strobe does not match the accepted beat.")

endmodule
